// File: hdl/akf_pkg.sv
// Shared types, constants and saturating helpers for the angle Kalman filter.
package akf_pkg;

  localparam int QW = 48;
  localparam int CW = 47;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [CW-1:0] cfg_t;

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
  } akf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } akf_out_t;

  // Register indexes
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_TIME_STEP   = 2'd3;

  localparam cfg_t RST_ANGLE_NOISE = 47'd4294967;
  localparam cfg_t RST_BIAS_NOISE  = 47'd4294967;
  localparam cfg_t RST_MEAS_NOISE  = 47'd42949672960;
  localparam cfg_t RST_TIME_STEP   = 47'd25769804;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam q_t Q_ONE = 48'sd4294967296;

  function automatic q_t add_sat(input q_t a, input q_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? Q_MIN : Q_MAX;
    return s[QW-1:0];
  endfunction

  function automatic q_t sub_sat(input q_t a, input q_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? Q_MIN : Q_MAX;
    return s[QW-1:0];
  endfunction

  function automatic q_t neg_sat(input q_t a);
    if (a == Q_MIN) return Q_MAX;
    return -a;
  endfunction

  // Magnitude; the most negative value maps to 2^47, which still fits
  function automatic logic [QW-1:0] mag(input q_t v);
    logic [QW-1:0] m;
    m = v[QW-1] ? QW'(-v) : v;
    return m;
  endfunction

  // Apply sign to a magnitude and clip to the 48-bit range
  function automatic q_t from_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m >= 64'h0000_8000_0000_0000) return Q_MIN;
      return -q_t'(m[QW-1:0]);
    end
    if (m > 64'h0000_7FFF_FFFF_FFFF) return Q_MAX;
    return q_t'(m[QW-1:0]);
  endfunction

endpackage

// File: hdl/akf_mul.sv
// Multi-cycle Q16.32 multiplier: 48x16 partial products, truncation, saturation.
module akf_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  akf_pkg::q_t a,
  input  akf_pkg::q_t b,
  output logic        done,
  output akf_pkg::q_t result
);
  import akf_pkg::*;

  logic [QW-1:0] ma;
  logic [QW-1:0] mb;
  logic          neg;
  logic [95:0]   acc;
  logic [1:0]    cnt;
  logic          run;
  logic          fin;
  logic [15:0]   chunk;
  logic [63:0]   part;

  // Digit of the second operand, most significant first
  always_comb begin
    case (cnt)
      2'd2:    chunk = mb[47:32];
      2'd1:    chunk = mb[31:16];
      default: chunk = mb[15:0];
    endcase
    part = {16'b0, ma} * {48'b0, chunk};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma  <= mag(a);
        mb  <= mag(b);
        neg <= a[QW-1] != b[QW-1];
        acc <= '0;
        cnt <= 2'd2;
        run <= 1'b1;
      end else if (run) begin
        acc <= {acc[79:0], 16'b0} + {32'b0, part};
        if (cnt == 2'd0) begin
          run <= 1'b0;
          fin <= 1'b1;
        end else begin
          cnt <= cnt - 2'd1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done   <= 1'b1;
        result <= from_mag(acc[95:32], neg);
      end
    end
  end
endmodule

// File: hdl/akf_div.sv
// Serial restoring divider for Q16.32 quotients, one quotient bit per cycle.
module akf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  akf_pkg::q_t n,
  input  akf_pkg::q_t d,
  output logic        done,
  output akf_pkg::q_t result
);
  import akf_pkg::*;

  logic [QW-1:0] md;
  logic          neg;
  logic [62:0]   rem;
  logic [46:0]   quo;
  logic [5:0]    cnt;
  logic          chk;
  logic          run;
  logic [62:0]   dsh;
  logic [62:0]   dov;
  // Marks a finished iteration whose result is not yet posted
  logic          quo_pend;

  // Divisor aligned to the top quotient bit, and the overflow limit
  assign dsh = {1'b0, md, 14'b0};
  assign dov = {md, 15'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      chk  <= 1'b0;
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        md  <= mag(d);
        neg <= n[QW-1] != d[QW-1];
        rem <= {15'b0, mag(n)};
        quo <= '0;
        cnt <= 6'd46;
        chk <= 1'b1;
      end else if (chk) begin
        // zero divisor and a quotient of 2^15 or more finish at once
        chk <= 1'b0;
        if (md == '0) begin
          result <= '0;
          done   <= 1'b1;
        end else if (rem >= dov) begin
          result <= neg ? Q_MIN : Q_MAX;
          done   <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        if (rem >= dsh) begin
          rem <= {rem[61:0] - dsh[61:0], 1'b0};
          quo <= {quo[45:0], 1'b1};
        end else begin
          rem <= {rem[61:0], 1'b0};
          quo <= {quo[45:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          run <= 1'b0;
          chk <= 1'b0;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
      // quotient is complete the cycle after the last step
      if (!start && !chk && !run && cnt == 6'd0 && !done && quo_pend) begin
        result <= from_mag({17'b0, quo}, neg);
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quo_pend <= 1'b0;
    end else if (run && cnt == 6'd0) begin
      quo_pend <= 1'b1;
    end else if (quo_pend && !run) begin
      quo_pend <= 1'b0;
    end
  end
endmodule

// File: hdl/angle_kalman_filter.sv
// Two-state angle / gyro-bias Kalman filter with a shared multiplier and divider.
// A division ends early on a zero divisor or a saturated gain. Ten multiplies and
// two divisions run one after another, in_ready is high only while idle, and a held
// result stalls the next.
// Reset: angle and bias clear, covariance loads the identity, registers load defaults.
module angle_kalman_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  akf_pkg::akf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output akf_pkg::akf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  akf_pkg::cfg_t     cfg_data
);
  import akf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_M_ANG = 4'd2;
  localparam logic [3:0] ST_M_P0  = 4'd3;
  localparam logic [3:0] ST_M_P12 = 4'd4;
  localparam logic [3:0] ST_M_P3  = 4'd5;
  localparam logic [3:0] ST_ERR   = 4'd6;
  localparam logic [3:0] ST_D_K0  = 4'd7;
  localparam logic [3:0] ST_D_K1  = 4'd8;
  localparam logic [3:0] ST_M_C3  = 4'd9;
  localparam logic [3:0] ST_M_C2  = 4'd10;
  localparam logic [3:0] ST_M_C1  = 4'd11;
  localparam logic [3:0] ST_M_C0  = 4'd12;
  localparam logic [3:0] ST_M_A   = 4'd13;
  localparam logic [3:0] ST_M_B   = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  logic [3:0] st;
  logic       pend;
  cfg_t       qa, qb, rn, dt;
  q_t         ang, bias, p0, p1, p2, p3;
  q_t         meas, rate, pd0, pd1, err, e, k0, k1;
  q_t         mul_a, mul_b, mul_res, div_n, div_res;
  logic       mul_go, mul_done, div_go, div_done, is_div, is_op;

  assign in_ready  = (st == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Operand selection for the shared units
  always_comb begin
    mul_a  = rate;
    mul_b  = q_t'({1'b0, dt});
    div_n  = p0;
    is_div = 1'b0;
    is_op  = 1'b1;
    unique case (st)
      ST_M_ANG: mul_a = rate;
      ST_M_P0:  mul_a = pd0;
      ST_M_P12: mul_a = pd1;
      ST_M_P3:  mul_a = q_t'({1'b0, qb});
      ST_D_K0:  begin div_n = p0; is_div = 1'b1; end
      ST_D_K1:  begin div_n = p2; is_div = 1'b1; end
      ST_M_C3:  begin mul_a = k1; mul_b = p1; end
      ST_M_C2:  begin mul_a = k1; mul_b = p0; end
      ST_M_C1:  begin mul_a = k0; mul_b = p1; end
      ST_M_C0:  begin mul_a = k0; mul_b = p0; end
      ST_M_A:   begin mul_a = k0; mul_b = err; end
      ST_M_B:   begin mul_a = k1; mul_b = err; end
      default:  is_op = 1'b0;
    endcase
    mul_go = is_op && !is_div && !pend;
    div_go = is_op && is_div && !pend;
  end

  akf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_res)
  );

  akf_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .n(div_n), .d(e),
    .done(div_done), .result(div_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= RST_ANGLE_NOISE;
      qb <= RST_BIAS_NOISE;
      rn <= RST_MEAS_NOISE;
      dt <= RST_TIME_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ANGLE_NOISE: qa <= cfg_data;
        REG_BIAS_NOISE:  qb <= cfg_data;
        REG_MEAS_NOISE:  rn <= cfg_data;
        default:         dt <= cfg_data;
      endcase
    end
  end

  // Step sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      ang       <= '0;
      bias      <= '0;
      p0        <= Q_ONE;
      p1        <= '0;
      p2        <= '0;
      p3        <= Q_ONE;
    end else begin
      if (out_valid && out_ready && st != ST_OUT) out_valid <= 1'b0;
      if (mul_go || div_go) pend <= 1'b1;
      if ((mul_done || div_done) && pend) pend <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            meas <= q_t'({in_data.accel_angle, 16'b0});
            rate <= q_t'({in_data.gyro_rate, 16'b0});
            st   <= ST_PREP;
          end
        end
        ST_PREP: begin
          rate <= sub_sat(rate, bias);
          pd0  <= sub_sat(sub_sat(q_t'({1'b0, qa}), p1), p2);
          pd1  <= neg_sat(p3);
          st   <= ST_M_ANG;
        end
        ST_M_ANG: if (mul_done && pend) begin ang <= add_sat(ang, mul_res); st <= ST_M_P0; end
        ST_M_P0:  if (mul_done && pend) begin p0 <= add_sat(p0, mul_res); st <= ST_M_P12; end
        ST_M_P12: if (mul_done && pend) begin
          p1 <= add_sat(p1, mul_res);
          p2 <= add_sat(p2, mul_res);
          st <= ST_M_P3;
        end
        ST_M_P3:  if (mul_done && pend) begin p3 <= add_sat(p3, mul_res); st <= ST_ERR; end
        ST_ERR: begin
          err <= sub_sat(meas, ang);
          e   <= add_sat(q_t'({1'b0, rn}), p0);
          st  <= ST_D_K0;
        end
        ST_D_K0: if (div_done && pend) begin k0 <= div_res; st <= ST_D_K1; end
        ST_D_K1: if (div_done && pend) begin k1 <= div_res; st <= ST_M_C3; end
        ST_M_C3: if (mul_done && pend) begin p3 <= sub_sat(p3, mul_res); st <= ST_M_C2; end
        ST_M_C2: if (mul_done && pend) begin p2 <= sub_sat(p2, mul_res); st <= ST_M_C1; end
        ST_M_C1: if (mul_done && pend) begin p1 <= sub_sat(p1, mul_res); st <= ST_M_C0; end
        ST_M_C0: if (mul_done && pend) begin p0 <= sub_sat(p0, mul_res); st <= ST_M_A; end
        ST_M_A:  if (mul_done && pend) begin ang <= add_sat(ang, mul_res); st <= ST_M_B; end
        ST_M_B:  if (mul_done && pend) begin bias <= add_sat(bias, mul_res); st <= ST_OUT; end
        default: begin
          // result waits for a free output register
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.angle_estimate <= ang[47:16];
            out_data.bias_estimate  <= bias[47:16];
            st                      <= ST_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// File: tb/angle_kalman_filter_tb.sv
// Self-checking testbench for the angle / gyro-bias Kalman filter block.
module angle_kalman_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import akf_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int RANDOM_PER_PH = 85;
  localparam int NUM_PHASES    = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  akf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  akf_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0] cfg_index = REG_ANGLE_NOISE;
  cfg_t     cfg_data = '0;

  typedef struct {
    logic [1:0] index;
    cfg_t       value;
  } reg_write_t;

  akf_in_t    sample_queue[$];
  reg_write_t reg_queue[$];
  akf_out_t   estimate_queue[$];

  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Filter state and register copies used for prediction
  q_t mdl_angle, mdl_bias;
  q_t mdl_cov[4];
  q_t mdl_q_angle, mdl_q_bias, mdl_r_meas, mdl_dt;

  angle_kalman_filter DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // 48-bit saturation of a wide signed value
  function automatic q_t clip48(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return {1'b0, {47{1'b1}}};
    if (v < -128'sh8000_0000_0000) return {1'b1, {47{1'b0}}};
    return v[47:0];
  endfunction

  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip48(wa + wb);
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip48(wa - wb);
  endfunction

  function automatic logic [127:0] abs_wide(input q_t a);
    logic signed [127:0] w;
    w = a;
    return (w < 0) ? -w : w;
  endfunction

  function automatic q_t signed_clip(input logic [127:0] m, input logic neg);
    logic signed [127:0] w;
    w = m;
    return clip48(neg ? -w : w);
  endfunction

  // Q16.32 product truncated toward zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [127:0] p;
    p = (abs_wide(a) * abs_wide(b)) >> 32;
    return signed_clip(p, a[47] ^ b[47]);
  endfunction

  // Q16.32 quotient truncated toward zero; zero divisor gives zero gain
  function automatic q_t qdiv(input q_t n, input q_t d);
    logic [127:0] mn, md, q;
    logic neg;
    mn = abs_wide(n);
    md = abs_wide(d);
    neg = n[47] ^ d[47];
    if (md == 0) return '0;
    if (mn / md >= 128'd32768) return signed_clip(128'h8000_0000_0000, neg);
    q = (mn << 32) / md;
    return signed_clip(q, neg);
  endfunction

  function automatic logic signed [31:0] to_port(input q_t v);
    q_t s;
    s = v >>> 16;
    return s[31:0];
  endfunction

  // One filter step: predict then correct, returns the expected estimates
  function automatic akf_out_t filter_step(input akf_in_t s);
    q_t meas, rate, pd0, pd1, err, e, k0, k1, t0, t1;
    akf_out_t r;
    meas = q_t'(s.accel_angle) <<< 16;
    rate = q_t'(s.gyro_rate) <<< 16;
    rate = ssub(rate, mdl_bias);
    mdl_angle = sadd(mdl_angle, qmul(rate, mdl_dt));
    pd0 = ssub(ssub(mdl_q_angle, mdl_cov[1]), mdl_cov[2]);
    pd1 = ssub('0, mdl_cov[3]);
    mdl_cov[0] = sadd(mdl_cov[0], qmul(pd0, mdl_dt));
    mdl_cov[1] = sadd(mdl_cov[1], qmul(pd1, mdl_dt));
    mdl_cov[2] = sadd(mdl_cov[2], qmul(pd1, mdl_dt));
    mdl_cov[3] = sadd(mdl_cov[3], qmul(mdl_q_bias, mdl_dt));
    err = ssub(meas, mdl_angle);
    e = sadd(mdl_r_meas, mdl_cov[0]);
    k0 = qdiv(mdl_cov[0], e);
    k1 = qdiv(mdl_cov[2], e);
    t0 = mdl_cov[0];
    t1 = mdl_cov[1];
    mdl_cov[0] = ssub(mdl_cov[0], qmul(k0, t0));
    mdl_cov[1] = ssub(mdl_cov[1], qmul(k0, t1));
    mdl_cov[2] = ssub(mdl_cov[2], qmul(k1, t0));
    mdl_cov[3] = ssub(mdl_cov[3], qmul(k1, t1));
    mdl_angle = sadd(mdl_angle, qmul(k0, err));
    mdl_bias = sadd(mdl_bias, qmul(k1, err));
    r.angle_estimate = to_port(mdl_angle);
    r.bias_estimate = to_port(mdl_bias);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        estimate_queue.push_back(filter_step(in_data));
      if (!(in_valid && !in_ready)) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGLE_NOISE: mdl_q_angle = {1'b0, cfg_data};
          REG_BIAS_NOISE:  mdl_q_bias  = {1'b0, cfg_data};
          REG_MEAS_NOISE:  mdl_r_meas  = {1'b0, cfg_data};
          REG_TIME_STEP:   mdl_dt      = {1'b0, cfg_data};
        endcase
      end
      if (!(cfg_valid && !cfg_ready)) begin
        if (reg_queue.size() > 0) begin
          cfg_index <= reg_queue[0].index;
          cfg_data <= reg_queue[0].value;
          void'(reg_queue.pop_front());
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (estimate_queue.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          akf_out_t want;
          want = estimate_queue.pop_front();
          if (out_data.angle_estimate !== want.angle_estimate)
            report_mismatch($sformatf("angle_estimate got %h want %h",
                                      out_data.angle_estimate, want.angle_estimate));
          if (out_data.bias_estimate !== want.bias_estimate)
            report_mismatch($sformatf("bias_estimate got %h want %h",
                                      out_data.bias_estimate, want.bias_estimate));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic akf_in_t make_sample(input int a, input int r);
    akf_in_t s;
    s.accel_angle = a;
    s.gyro_rate = r;
    return s;
  endfunction

  // Mostly plausible IMU readings, some full-range words
  function automatic akf_in_t random_sample();
    akf_in_t s;
    if ($urandom_range(3) == 0) begin
      s.accel_angle = $urandom;
      s.gyro_rate = $urandom;
    end else begin
      s.accel_angle = $signed($urandom_range(11796480)) - 5898240;
      s.gyro_rate = $signed($urandom_range(65536000)) - 32768000;
    end
    return s;
  endfunction

  function automatic cfg_t rand_cfg(input int bits);
    logic [63:0] w;
    w = {$urandom, $urandom};
    return cfg_t'(w & ((64'd1 << bits) - 1));
  endfunction

  task automatic write_regs(input cfg_t qa, input cfg_t qb, input cfg_t rm, input cfg_t dt);
    reg_write_t w;
    w.index = REG_ANGLE_NOISE; w.value = qa; reg_queue.push_back(w);
    w.index = REG_BIAS_NOISE;  w.value = qb; reg_queue.push_back(w);
    w.index = REG_MEAS_NOISE;  w.value = rm; reg_queue.push_back(w);
    w.index = REG_TIME_STEP;   w.value = dt; reg_queue.push_back(w);
    do @(posedge clk); while (reg_queue.size() > 0 || cfg_valid);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() > 0 || in_valid || estimate_queue.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  localparam cfg_t CFG_MAX = {47{1'b1}};

  initial begin
    mdl_angle = '0;
    mdl_bias = '0;
    mdl_cov[0] = 48'sd4294967296;
    mdl_cov[1] = '0;
    mdl_cov[2] = '0;
    mdl_cov[3] = 48'sd4294967296;
    mdl_q_angle = {1'b0, RST_ANGLE_NOISE};
    mdl_q_bias = {1'b0, RST_BIAS_NOISE};
    mdl_r_meas = {1'b0, RST_MEAS_NOISE};
    mdl_dt = {1'b0, RST_TIME_STEP};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // register setting for this phase
      case (ph)
        0: ;  // reset defaults
        1: write_regs('0, '0, '0, '0);          // zero noise and time step
        2: write_regs(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        3: write_regs(rand_cfg(24), rand_cfg(24), rand_cfg(36), rand_cfg(26));
        4: write_regs(RST_ANGLE_NOISE, RST_BIAS_NOISE, '0, CFG_MAX);
        5: write_regs(rand_cfg(47), rand_cfg(47), rand_cfg(47), rand_cfg(47));
        6: write_regs(rand_cfg(20), rand_cfg(20), 47'd1, rand_cfg(34));
        default: write_regs(RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEAS_NOISE, RST_TIME_STEP);
      endcase
      // directed items
      if (ph == 0) begin
        sample_queue.push_back(make_sample(0, 0));
        sample_queue.push_back(make_sample(32'h7FFFFFFF, 32'h7FFFFFFF));
        sample_queue.push_back(make_sample(32'h80000000, 32'h80000000));
        sample_queue.push_back(make_sample(32'h7FFFFFFF, 32'h80000000));
        sample_queue.push_back(make_sample(32'h80000000, 32'h7FFFFFFF));
        sample_queue.push_back(make_sample(1, -1));
        sample_queue.push_back(make_sample(-1, 1));
        sample_queue.push_back(make_sample(32'h55555555, 32'hAAAAAAAA));
        sample_queue.push_back(make_sample(32'hAAAAAAAA, 32'h55555555));
      end else if (ph == 1 || ph == 2) begin
        sample_queue.push_back(make_sample(65536, 0));
        sample_queue.push_back(make_sample(0, 65536));
        sample_queue.push_back(make_sample(32'h7FFFFFFF, 32'h80000000));
        sample_queue.push_back(make_sample(32'h80000000, 32'h7FFFFFFF));
        sample_queue.push_back(make_sample(0, 0));
        sample_queue.push_back(make_sample(-65536, -65536));
      end
      for (int i = 0; i < RANDOM_PER_PH; i++)
        sample_queue.push_back(random_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
